FILE: hdl/gjmi_pkg.sv
package gjmi_pkg;
  localparam int FRAC_BITS = 16;
  localparam int ORDER_W = 4;
endpackage

FILE: hdl/gjmi_recip.sv
// Rounded 2^(2*FRAC_BITS) / |m|, one quotient bit a cycle, with sign and clip.
module gjmi_recip
  import gjmi_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic                         clipped
);
  localparam int NW = 2 * FRAC_BITS + DATA_WIDTH + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]       num_r, num_nxt;
  logic [DATA_WIDTH:0] rem_r, rem_nxt;
  logic [DATA_WIDTH:0] den_r;
  logic                neg_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DATA_WIDTH:0] rem_sh;
  logic [DATA_WIDTH:0] mag;
  logic [NW-1:0]       q_mag;
  logic [DATA_WIDTH:0] lim;

  assign mag = divisor[DATA_WIDTH-1] ? ({1'b0, ~divisor} + 1'b1) : {1'b0, divisor};
  assign done = done_r;

  always_comb begin
    rem_sh  = {rem_r[DATA_WIDTH-1:0], num_r[NW-1]};
    num_nxt = {num_r[NW-2:0], 1'b0};
    rem_nxt = rem_sh;
    if (rem_sh >= den_r) begin
      rem_nxt    = rem_sh - den_r;
      num_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        // numerator is 2^32 + |m|/2 so truncation gives the rounded result
        num_r  <= (NW'(1) << (2 * FRAC_BITS)) + NW'(mag >> 1);
        rem_r  <= '0;
        den_r  <= mag;
        neg_r  <= divisor[DATA_WIDTH-1];
      end else if (busy_r) begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign q_mag = num_r;
  assign lim   = neg_r ? ({1'b1, {DATA_WIDTH{1'b0}}} >> 1) :
                         (({1'b1, {DATA_WIDTH{1'b0}}} >> 1) - 1'b1);

  always_comb begin
    clipped  = (q_mag > NW'(lim));
    if (clipped)
      quotient = neg_r ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    else
      quotient = neg_r ? DATA_WIDTH'(-q_mag) : DATA_WIDTH'(q_mag);
  end
endmodule

FILE: hdl/gjmi_mac.sv
// Two-stage saturating multiply then subtract: y = a - (b*c rounded).
// With sub_en low, y = b*c rounded.
module gjmi_mac
  import gjmi_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  input  logic signed [DATA_WIDTH-1:0] c,
  input  logic                         sub_en,
  output logic signed [DATA_WIDTH-1:0] y,
  output logic                         clipped
);
  localparam int PW = 2 * DATA_WIDTH;
  localparam logic signed [DATA_WIDTH:0] VMAX = (DATA_WIDTH+1)'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [DATA_WIDTH:0] VMIN = -VMAX - 1;

  logic [DATA_WIDTH-1:0] ma, mb;
  logic                  neg;
  logic [PW-1:0]         prod_r;
  logic                  neg_r, sub_r;
  logic signed [DATA_WIDTH-1:0] a_r;
  logic [PW:0]           rnd;
  logic [PW:0]           pmag;
  logic signed [DATA_WIDTH:0] p;
  logic                  pclip;
  logic signed [DATA_WIDTH+1:0] diff;

  function automatic logic [DATA_WIDTH-1:0] a_sign(input logic signed [DATA_WIDTH-1:0] v);
    a_sign = v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : DATA_WIDTH'(v);
  endfunction

  assign ma  = a_sign(b);
  assign mb  = a_sign(c);
  assign neg = b[DATA_WIDTH-1] ^ c[DATA_WIDTH-1];

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    neg_r  <= neg;
    sub_r  <= sub_en;
    a_r    <= a;
  end

  always_comb begin
    rnd  = {1'b0, prod_r} + (PW+1)'(1 << (FRAC_BITS - 1));
    pmag = rnd >> FRAC_BITS;
    if (neg_r) begin
      pclip = pmag > (PW+1)'({1'b1, {(DATA_WIDTH-1){1'b0}}});
      p     = pclip ? VMIN : -(DATA_WIDTH+1)'(pmag);
    end else begin
      pclip = pmag > (PW+1)'({(DATA_WIDTH-1){1'b1}});
      p     = pclip ? VMAX : (DATA_WIDTH+1)'(pmag);
    end
    diff = (DATA_WIDTH+2)'(a_r) - (DATA_WIDTH+2)'(p);
    if (!sub_r) begin
      y       = DATA_WIDTH'(p);
      clipped = pclip;
    end else if (diff > (DATA_WIDTH+2)'(VMAX)) begin
      y       = DATA_WIDTH'(VMAX);
      clipped = 1'b1;
    end else if (diff < (DATA_WIDTH+2)'(VMIN)) begin
      y       = DATA_WIDTH'(VMIN);
      clipped = 1'b1;
    end else begin
      y       = DATA_WIDTH'(diff);
      clipped = pclip;
    end
  end
endmodule

FILE: hdl/gauss_jordan_matrix_inverse_core.sv
// Gauss-Jordan inverter with partial pivoting, Q16.16 saturating arithmetic.
// Load: one element per cycle, unless a register write holds the input. Elimination:
// per pivot column a search over the candidate rows, a reciprocal of the pivot, a row
// swap where needed, then 2n words per row through one multiply-subtract unit (word
// reads, two MAC stages, write). Emit: each element is read, then held. Throughput is
// set by the single store and the one MAC. Synchronous active-low reset; no clearing.
module gauss_jordan_matrix_inverse_core
  import gjmi_pkg::*;
#(
  parameter int MAX_ORDER  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_WIDTH-1:0] in_tdata,   // element_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_WIDTH-1:0] out_tdata,  // inverse_value
  output logic                  out_tlast,  // is_last
  output logic [1:0]            out_tuser,  // saturated, singular
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [1:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  localparam int RW   = $clog2(MAX_ORDER);
  localparam int CLW  = $clog2(2 * MAX_ORDER);
  localparam int AW   = RW + CLW;
  localparam int DEP  = 1 << AW;
  localparam int NW   = $clog2(MAX_ORDER + 1);
  localparam int LCW  = $clog2(MAX_ORDER * MAX_ORDER + 1);
  // 1.0 clips when the word has no room for it
  localparam bit ONE_CLIP = (DATA_WIDTH - 1 <= FRAC_BITS);
  localparam logic [DATA_WIDTH-1:0] ONE_Q = ONE_CLIP ? {1'b0, {(DATA_WIDTH-1){1'b1}}}
                                                     : DATA_WIDTH'(1) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_PSRD, S_PSCMP, S_RCP, S_RCPW, S_SWRD, S_SWW1, S_SWW2,
    S_SCRD, S_SCM, S_SCW, S_FRD, S_FWT, S_ERD, S_ERD2, S_EM, S_EW, S_NEXTR,
    S_NEXTC, S_ORD, S_OUT
  } st_t;

  st_t st_r;

  // configuration
  logic [ORDER_W-1:0] order_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 2'd0);
  assign cfg_prdata = {{(32-ORDER_W){1'b0}}, order_r};

  logic [NW-1:0] n;
  always_comb begin
    if (order_r == '0) n = NW'(1);
    else if (order_r > ORDER_W'(MAX_ORDER)) n = NW'(MAX_ORDER);
    else n = NW'(order_r);
  end

  // store, one write port and one read port
  logic [DATA_WIDTH-1:0] mem [DEP];
  logic                  we;
  logic [AW-1:0]         wa, ra;
  logic [DATA_WIDTH-1:0] wd, rd_r;
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  logic [LCW-1:0] lcnt_r;
  logic [RW:0]    lr_r, i_r, u_r, k_r, best_r;
  logic [CLW:0]   c_r, j_r;
  logic [DATA_WIDTH-1:0] piv_r, rcp_r, fac_r, tmp_r;
  logic sing_r, sat_r;
  logic last_r;

  function automatic logic [DATA_WIDTH-1:0] amag(input logic [DATA_WIDTH-1:0] v);
    amag = v[DATA_WIDTH-1] ? -v : v;
  endfunction

  function automatic logic [AW-1:0] adr(input logic [RW:0] r, input logic [CLW:0] c);
    adr = {r[RW-1:0], c[CLW-1:0]};
  endfunction

  // reciprocal
  logic rcp_start, rcp_done, rcp_clip;
  logic signed [DATA_WIDTH-1:0] rcp_q;
  gjmi_recip #(.DATA_WIDTH(DATA_WIDTH)) u_recip (
    .clk(clk), .rst_n(rst_n), .start(rcp_start), .divisor(piv_r),
    .done(rcp_done), .quotient(rcp_q), .clipped(rcp_clip));

  // MAC: scaling uses b=row word, c=rcp, no sub; S_EM uses a=target, b=pivot word, c=fac
  logic [DATA_WIDTH-1:0] mac_y;
  logic mac_clip, mac_sub;
  gjmi_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk(clk), .a(rd_r), .b(tmp_r),
    .c((st_r == S_SCM || st_r == S_SCW) ? rcp_r : fac_r),
    .sub_en(mac_sub), .y(mac_y), .clipped(mac_clip));
  logic [1:0] ph_r;

  // a register write takes the cycle, so the load waits for it
  assign in_tready = (st_r == S_LOAD) && !cfg_wr;
  logic [CLW:0] w2;
  assign w2 = (CLW+1)'(2 * n);

  always_comb begin
    we = 1'b0; wa = '0; wd = '0; ra = '0; rcp_start = 1'b0; mac_sub = 1'b0;
    unique case (st_r)
      S_LOAD: begin
        we = in_tvalid && in_tready;
        wa = adr(lr_r, c_r);
        wd = in_tdata;
      end
      S_INIT: begin
        we = 1'b1;
        wa = adr(lr_r, c_r + (CLW+1)'(n));
        wd = (lr_r == (RW+1)'(c_r)) ? ONE_Q : '0;
      end
      S_PSRD: ra = adr(k_r, j_r);
      S_RCP: rcp_start = (piv_r != '0);
      S_SWRD: ra = adr(i_r, c_r);
      S_SWW1: ra = adr(best_r, c_r);
      S_SWW2: begin
        we = 1'b1; wa = adr(best_r, c_r); wd = tmp_r;
      end
      S_SCRD: ra = adr(i_r, c_r);
      S_SCW: begin
        we = (ph_r == 2'd1); wa = adr(i_r, c_r); wd = mac_y;
      end
      S_FRD: ra = adr(u_r, j_r);
      S_ERD: ra = adr(i_r, c_r);
      S_ERD2: ra = adr(u_r, c_r);
      S_EM: mac_sub = 1'b1;
      S_EW: begin
        mac_sub = 1'b1;
        we = 1'b1; wa = adr(u_r, c_r); wd = mac_y;
      end
      S_ORD: ra = adr(lr_r, c_r + (CLW+1)'(n));
      default: ;
    endcase
    if (st_r == S_SWW1 && ph_r == 2'd1) begin
      we = 1'b1; wa = adr(i_r, c_r); wd = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; order_r <= ORDER_W'(8); lcnt_r <= '0; lr_r <= '0; c_r <= '0;
      sing_r <= 1'b0; sat_r <= 1'b0; out_tvalid <= 1'b0; ph_r <= '0;
    end else begin
      if (cfg_wr) order_r <= cfg_pwdata[ORDER_W-1:0];
      unique case (st_r)
        S_LOAD: if (cfg_wr) begin
          // new order: loading restarts with the next element
          lcnt_r <= '0; lr_r <= '0; c_r <= '0;
        end else if (in_tvalid) begin
          if (lcnt_r + 1'b1 == LCW'(n) * LCW'(n)) begin
            st_r <= S_INIT; lr_r <= '0; c_r <= '0;
          end else begin
            lcnt_r <= lcnt_r + 1'b1;
            if (c_r + 1'b1 == (CLW+1)'(n)) begin
              c_r <= '0; lr_r <= lr_r + 1'b1;
            end else c_r <= c_r + 1'b1;
          end
        end
        S_INIT: begin
          if (ONE_CLIP) sat_r <= 1'b1;
          if (c_r + 1'b1 == (CLW+1)'(n)) begin
            c_r <= '0;
            if (lr_r + 1'b1 == (RW+1)'(n)) begin
              st_r <= S_PSRD; i_r <= '0; j_r <= '0; k_r <= '0; best_r <= '0;
              piv_r <= '0;
            end else lr_r <= lr_r + 1'b1;
          end else c_r <= c_r + 1'b1;
        end
        S_PSRD: st_r <= S_PSCMP;
        S_PSCMP: begin
          // first row in range is taken as is; later ones replace only if larger
          if (k_r == i_r || amag(rd_r) > amag(piv_r)) begin
            piv_r <= rd_r; best_r <= k_r;
          end
          if (k_r + 1'b1 == (RW+1)'(n)) st_r <= S_RCP;
          else begin k_r <= k_r + 1'b1; st_r <= S_PSRD; end
        end
        S_RCP: begin
          if (piv_r == '0) begin
            sing_r <= 1'b1; st_r <= S_NEXTC;
          end else st_r <= S_RCPW;
        end
        S_RCPW: if (rcp_done) begin
          rcp_r <= rcp_q;
          if (rcp_clip) sat_r <= 1'b1;
          c_r <= '0; ph_r <= '0;
          st_r <= (best_r == i_r) ? S_SCRD : S_SWRD;
        end
        S_SWRD: st_r <= S_SWW1;
        S_SWW1: begin
          if (ph_r == 2'd0) begin tmp_r <= rd_r; ph_r <= 2'd1; end
          else begin ph_r <= 2'd0; st_r <= S_SWW2; end
        end
        S_SWW2: begin
          if (c_r + 1'b1 == w2) begin c_r <= '0; st_r <= S_SCRD; end
          else begin c_r <= c_r + 1'b1; st_r <= S_SWRD; end
        end
        S_SCRD: st_r <= S_SCM;
        S_SCM: begin tmp_r <= rd_r; ph_r <= 2'd0; st_r <= S_SCW; end
        S_SCW: begin
          if (ph_r == 2'd0) ph_r <= 2'd1;
          else begin
            ph_r <= 2'd0;
            if (mac_clip) sat_r <= 1'b1;
            if (c_r + 1'b1 == w2) begin
              c_r <= '0; u_r <= '0; st_r <= S_NEXTR;
            end else begin c_r <= c_r + 1'b1; st_r <= S_SCRD; end
          end
        end
        S_NEXTR: begin
          if (u_r == (RW+1)'(n)) begin
            i_r <= i_r + 1'b1; st_r <= S_NEXTC;
          end else if (u_r == i_r) u_r <= u_r + 1'b1;
          else st_r <= S_FRD;
        end
        S_FRD: st_r <= S_FWT;
        S_FWT: begin fac_r <= rd_r; c_r <= '0; st_r <= S_ERD; end
        S_ERD: st_r <= S_ERD2;
        S_ERD2: begin tmp_r <= rd_r; st_r <= S_EM; end
        S_EM: st_r <= S_EW;
        S_EW: begin
          if (mac_clip) sat_r <= 1'b1;
          if (c_r + 1'b1 == w2) begin
            u_r <= u_r + 1'b1; st_r <= S_NEXTR;
          end else begin c_r <= c_r + 1'b1; st_r <= S_ERD; end
        end
        S_NEXTC: begin
          if (i_r == (RW+1)'(n) || j_r + 1'b1 == w2) begin
            st_r <= S_ORD; lr_r <= '0; c_r <= '0;
          end else begin
            j_r <= j_r + 1'b1; k_r <= i_r; best_r <= i_r; piv_r <= '0;
            st_r <= S_PSRD;
          end
        end
        S_ORD: begin
          last_r <= (lr_r + 1'b1 == (RW+1)'(n)) && (c_r + 1'b1 == (CLW+1)'(n));
          st_r <= S_OUT; ph_r <= 2'd0;
        end
        S_OUT: begin
          if (!out_tvalid && ph_r == 2'd0) begin
            out_tvalid <= 1'b1;
            out_tdata  <= rd_r;
            out_tlast  <= last_r;
            out_tuser  <= {sat_r, sing_r};
            ph_r <= 2'd1;
          end else if (out_tvalid && out_tready) begin
            out_tvalid <= 1'b0;
            if (last_r) begin
              st_r <= S_LOAD; lcnt_r <= '0; lr_r <= '0; c_r <= '0;
              sing_r <= 1'b0; sat_r <= 1'b0;
            end else begin
              if (c_r + 1'b1 == (CLW+1)'(n)) begin
                c_r <= '0; lr_r <= lr_r + 1'b1;
              end else c_r <= c_r + 1'b1;
              st_r <= S_ORD;
            end
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  // a new matrix element is never taken while results are pending
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("input open while result pending");
  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed under stall");
  // a reciprocal started on a nonzero pivot is followed by the wait state
  assert property (@(posedge clk) disable iff (!rst_n) rcp_start && piv_r != '0 |=> st_r == S_RCPW)
    else $error("reciprocal start out of sequence");
endmodule

FILE: test/gauss_jordan_matrix_inverse_core_test.sv
module gauss_jordan_matrix_inverse_core_test;
  import gjmi_pkg::*;

  localparam int MAXN = 8;
  localparam int DW = 32;
  localparam int COLS = 2 * MAXN;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int ADDR_ORDER = 0;          // matrix_order register
  localparam int WATCHDOG = 80000;        // idle limit; must cover a full n=8 elimination
  localparam int N_ITEMS = 480;

  typedef struct {
    logic [DW-1:0] val;
    bit            last;
    logic [1:0]    user;                  // saturated, singular
  } inv_word_t;

  typedef struct {
    logic [ORDER_W-1:0] ord;
    logic [DW-1:0]      val;
    bit                 chk;              // expectation typed in below
    logic [DW-1:0]      ev;
    logic [1:0]         eu;
  } dir_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [DW-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [DW-1:0] out_tdata;
  logic out_tlast;
  logic [1:0] out_tuser;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  gauss_jordan_matrix_inverse_core dut (.*);

  // model state of the inverter
  longint aug [MAXN][COLS];
  int unsigned load_cnt;
  bit sing_mark, sat_mark;
  logic [ORDER_W-1:0] order_reg;

  inv_word_t inverse_q[$];
  int errs;

  // handshakes sampled mid-cycle, so nothing races the clock edge
  bit in_fire, out_fire;
  logic [DW-1:0] out_d;
  logic out_l;
  logic [1:0] out_u;
  int idle_cycles;
  bit no_gaps;

  dir_row_t dir_tab [19];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    in_fire  <= in_tvalid & in_tready;
    out_fire <= out_tvalid & out_tready;
    out_d    <= out_tdata;
    out_l    <= out_tlast;
    out_u    <= out_tuser;
  end

  // ---------------- predictor ----------------
  function automatic longint q_clip(bit neg, longint unsigned mag);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (mag > lim) begin
      sat_mark = 1;
      return neg ? VMIN : VMAX;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned q_abs(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  // product rounded half away from zero, 16 fraction bits dropped
  function automatic longint q_mul(longint a, longint b);
    longint unsigned p;
    p = q_abs(a) * q_abs(b) + 64'd32768;
    return q_clip((a < 0) != (b < 0), p >> FRAC_BITS);
  endfunction

  function automatic longint q_sub(longint a, longint b);
    longint d;
    d = a - b;
    if (d > VMAX) begin
      sat_mark = 1;
      return VMAX;
    end
    if (d < VMIN) begin
      sat_mark = 1;
      return VMIN;
    end
    return d;
  endfunction

  function automatic longint q_recip(longint m);
    longint unsigned um;
    um = q_abs(m);
    return q_clip(m < 0, ((64'd1 << 32) + um / 2) / um);
  endfunction

  function automatic void gj_eliminate(int n);
    int i, j, best;
    longint piv, r, f, t;
    i = 0;
    j = 0;
    while (i < n && j < 2 * n) begin
      best = i;
      piv = aug[i][j];
      for (int k = i + 1; k < n; k++)
        if (q_abs(aug[k][j]) > q_abs(piv)) begin
          piv = aug[k][j];
          best = k;
        end
      if (piv != 0) begin
        for (int k = 0; k < COLS; k++) begin
          t = aug[i][k];
          aug[i][k] = aug[best][k];
          aug[best][k] = t;
        end
        r = q_recip(piv);
        for (int k = 0; k < 2 * n; k++) aug[i][k] = q_mul(aug[i][k], r);
        for (int u = 0; u < n; u++) begin
          if (u != i) begin
            f = aug[u][j];
            for (int k = 0; k < 2 * n; k++)
              aug[u][k] = q_sub(aug[u][k], q_mul(aug[i][k], f));
          end
        end
        i++;
      end else begin
        sing_mark = 1;
      end
      j++;
    end
  endfunction

  // one accepted element; returns number of inverse words queued
  function automatic int gj_accept(logic [DW-1:0] v);
    int n;
    inv_word_t w;
    n = order_reg;
    if (n < 1) n = 1;
    if (n > MAXN) n = MAXN;
    if (load_cnt >= n * n) load_cnt = 0;
    aug[load_cnt / n][load_cnt % n] = longint'($signed(v));
    load_cnt++;
    if (load_cnt < n * n) return 0;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        aug[r][n + c] = (r == c) ? 64'sd65536 : 0;
    gj_eliminate(n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        w.val = aug[r][n + c][DW-1:0];
        w.last = (r * n + c == n * n - 1);
        w.user = {sat_mark, sing_mark};
        inverse_q.insert(inverse_q.size(), w);
      end
    load_cnt = 0;
    sing_mark = 0;
    sat_mark = 0;
    return n * n;
  endfunction

  // ---------------- drivers ----------------
  function automatic int rand_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_elem(logic [DW-1:0] v, output int produced);
    int g;
    g = rand_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_fire);
    produced = gj_accept(v);
  endtask

  task automatic drain_idle();
    in_tvalid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);           // block may still be finishing up
  endtask

  task automatic write_order(logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_ORDER[1:0];
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    order_reg = v[ORDER_W-1:0];
    load_cnt = 0;
  endtask

  function automatic logic [DW-1:0] rand_elem(int kind);
    int r;
    r = $urandom_range(0, 99);
    if (kind == 1 && r < 40) return '0;                 // sparse, often singular
    if (kind == 2) return $urandom();                   // full range, saturating
    if (r < 75) return $urandom_range(0, 32'h80000) - 32'h40000;
    if (r < 85) return ($urandom_range(0, 8) - 4) << FRAC_BITS;
    if (r < 95) return $urandom();
    return '0;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) < 70 ? 1'b1
                    : ($urandom_range(0, 19) == 0 ? 1'b0 : $urandom_range(0, 1)));
      if (out_fire) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected request data=%h last=%b user=%b",
                   $time, out_d, out_l, out_u);
          errs++;
        end else begin
          inv_word_t e;
          e = inverse_q.pop_front();
          if (e.val !== out_d) begin
            $display("%0t: inverse_value exp %h got %h", $time, e.val, out_d);
            errs++;
          end
          if (e.last !== out_l) begin
            $display("%0t: tlast exp %b got %b", $time, e.last, out_l);
            errs++;
          end
          if (e.user !== out_u) begin
            $display("%0t: tuser exp %b got %b", $time, e.user, out_u);
            errs++;
          end
        end
      end
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if (in_fire || out_fire || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    int produced, sent, n, mats, kind, part;
    logic [31:0] ov;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errs = 0;
    no_gaps = 0;
    load_cnt = 0;
    sing_mark = 0;
    sat_mark = 0;
    order_reg = 4'd8;
    for (int r = 0; r < MAXN; r++)
      for (int c = 0; c < COLS; c++) aug[r][c] = 0;

    // directed: identity, zero pivot, extremes, tiny pivot, order 0, 2x2, all-zero 3x3
    dir_tab[0]  = '{4'd1, 32'h0001_0000, 1, 32'h0001_0000, 2'b00};
    dir_tab[1]  = '{4'd1, 32'h0000_0000, 1, 32'h0001_0000, 2'b01};
    dir_tab[2]  = '{4'd1, 32'h7fff_ffff, 0, '0, '0};
    dir_tab[3]  = '{4'd1, 32'h8000_0000, 0, '0, '0};
    dir_tab[4]  = '{4'd1, 32'h0000_0001, 1, 32'h7fff_ffff, 2'b10};
    dir_tab[5]  = '{4'd0, 32'hffff_0000, 1, 32'hffff_0000, 2'b00};
    dir_tab[6]  = '{4'd2, 32'h0002_0000, 0, '0, '0};
    dir_tab[7]  = '{4'd2, 32'h0000_0000, 0, '0, '0};
    dir_tab[8]  = '{4'd2, 32'h0000_0000, 0, '0, '0};
    dir_tab[9]  = '{4'd2, 32'hffff_8000, 0, '0, '0};
    for (int i = 10; i < 19; i++) dir_tab[i] = '{4'd3, 32'h0, 0, '0, '0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 19; i++) begin
      if (dir_tab[i].ord != order_reg) begin
        drain_idle();
        write_order({28'd0, dir_tab[i].ord});
      end
      send_elem(dir_tab[i].val, produced);
      if (dir_tab[i].chk && produced == 1) begin
        // replace the prediction by the hand-worked value
        void'(inverse_q.pop_back());
        inverse_q.insert(inverse_q.size(), inv_word_t'{dir_tab[i].ev, 1'b1, dir_tab[i].eu});
      end
    end

    // random phases: mostly small orders, a few at the largest
    sent = 0;
    while (sent < N_ITEMS) begin
      drain_idle();                       // sender waits for every result here
      part = $urandom_range(0, 99);
      if (part < 6) ov = 32'd8;
      else if (part < 9) ov = 32'd15;
      else if (part < 12) ov = 32'd0;
      else if (part < 20) ov = $urandom_range(5, 7);
      else ov = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) ov = ov | ($urandom() & 32'hffff_fff0);
      write_order(ov);
      no_gaps = ($urandom_range(0, 4) == 0);
      n = (order_reg < 1) ? 1 : (order_reg > MAXN ? MAXN : order_reg);
      // order write in the middle of a load restarts it
      if ($urandom_range(0, 7) == 0) begin
        part = $urandom_range(1, n * n);
        repeat (part - 1) begin
          send_elem(rand_elem(0), produced);
          sent++;
        end
        drain_idle();
        write_order(ov);
      end
      mats = (n > 4) ? 1 : $urandom_range(1, 4);
      repeat (mats) begin
        part = $urandom_range(0, 99);
        kind = part < 70 ? 0 : (part < 88 ? 1 : 2);
        repeat (n * n) begin
          send_elem(rand_elem(kind), produced);
          sent++;
        end
      end
    end

    in_tvalid <= 1'b0;
    no_gaps = 0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errs == 0 && inverse_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/gjmi_pkg.sv
hdl/gjmi_recip.sv
hdl/gjmi_mac.sv
hdl/gauss_jordan_matrix_inverse_core.sv
test/gauss_jordan_matrix_inverse_core_test.sv
